@@ rtl/sha1mh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message hasher package
// Shared types, hash constants and block padding helper.
// ----------------------------------------------------------------------------
package sha1mh_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [15:0][31:0] t_block;
    typedef logic [4:0][31:0]  t_chain;

    localparam int ROUNDS       = 80;
    localparam int COUNT_W      = 61;

    localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
    localparam logic [6:0] ROUND_B1   = 7'd20;
    localparam logic [6:0] ROUND_B2   = 7'd40;
    localparam logic [6:0] ROUND_B3   = 7'd60;

    localparam logic [6:0] PAD_OFF   = 7'd64;
    localparam logic [6:0] LEN_LIMIT = 7'd56;
    localparam logic [7:0] PAD_MARK  = 8'h80;

    localparam t_chain INIT_HASH = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                    32'hefcdab89, 32'h67452301};

    localparam t_word K_0 = 32'h5a827999;
    localparam t_word K_1 = 32'h6ed9eba1;
    localparam t_word K_2 = 32'h8f1bbcdc;
    localparam t_word K_3 = 32'hca62c1d6;

    typedef struct packed {
        logic       start;
        logic [6:0] pad_pos;
        logic       mark_en;
        logic       len_en;
    } t_cmp_req;

    // Bytes before the pad position pass, the pad position may take the
    // marker byte, and everything after it reads as zero.
    function automatic t_word pad_word(input logic [3:0] idx, input t_word raw,
                                       input logic [6:0] pad_pos, input logic mark_en);
        t_word      res;
        logic [6:0] pos;
        res = '0;
        for (int b = 0; b < 4; b++) begin
            pos = {1'b0, idx, 2'(b)};
            if (pos < pad_pos) begin
                res[31 - 8 * b -: 8] = raw[31 - 8 * b -: 8];
            end else if (pos == pad_pos && mark_en) begin
                res[31 - 8 * b -: 8] = PAD_MARK;
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/sha1_message_hasher_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message hasher
// Hashes a byte stream into a 160-bit digest delivered as five words.
// ----------------------------------------------------------------------------
// The slave stream takes one beat per message byte: tdata carries the byte,
// tuser says whether a byte is present and tlast ends the message, so a beat
// with tlast and no byte closes a message (or hashes an empty one).
// Bytes that do not complete a 64-byte block are taken one per cycle. The
// beat that completes a block drops tready while the compression core runs
// its 80 rounds, one per cycle, through one shared adder path. The closing
// beat pads the message and runs one or two more blocks (two when 56 or
// more bytes are pending), then the master stream presents the digest as
// five beats, most significant word first, with tuser giving the word
// position and tlast on the fifth word. A stalled receiver simply holds the
// current digest beat; no input is taken until all five are delivered.
// After the last digest beat the chaining values, byte count and fill level
// are back at their initial values. Synchronous reset returns the block to
// the same state and drops all valid outputs.
// ----------------------------------------------------------------------------
module sha1_message_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word[31:0]
    output logic [2:0]  m_axis_tuser,   // word_index[2:0]
    output logic        m_axis_tlast
);
    import sha1mh_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        N_IDLE,
        N_FINAL,
        N_LENGTH,
        N_EMIT
    } t_next;

    localparam logic [2:0] WORD_LAST = 3'd4;

    t_state               r_state;
    t_next                r_next;
    t_cmp_req             r_req;
    t_block               r_block;
    t_chain               r_chain;
    logic [5:0]           r_fill;
    logic [COUNT_W-1:0]   r_count;
    logic [2:0]           r_widx;

    logic [6:0] w_fill_nxt;
    logic       w_done;
    t_chain     w_work;

    assign w_fill_nxt = {1'b0, r_fill} + 7'(s_axis_tuser);

    sha1mh_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (r_req),
        .i_block   (r_block),
        .i_chain   (r_chain),
        .i_bit_len ({r_count, 3'b000}),
        .o_done    (w_done),
        .o_work    (w_work)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_next    <= N_IDLE;
            r_req     <= '0;
            r_chain   <= INIT_HASH;
            r_fill    <= '0;
            r_count   <= '0;
            r_widx    <= '0;
        end else begin
            r_req.start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser) begin
                            r_block[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= s_axis_tdata;
                            r_count <= r_count + COUNT_W'(1);
                            r_fill  <= w_fill_nxt[5:0];
                        end
                        if (w_fill_nxt == PAD_OFF) begin
                            r_req   <= '{start: 1'b1, pad_pos: PAD_OFF, mark_en: 1'b0,
                                         len_en: 1'b0};
                            r_next  <= s_axis_tlast ? N_FINAL : N_IDLE;
                            r_state <= S_WAIT;
                        end else if (s_axis_tlast) begin
                            r_req   <= '{start: 1'b1, pad_pos: w_fill_nxt, mark_en: 1'b1,
                                         len_en: (w_fill_nxt < LEN_LIMIT)};
                            r_next  <= (w_fill_nxt < LEN_LIMIT) ? N_EMIT : N_LENGTH;
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (w_done) begin
                        for (int i = 0; i < 5; i++) begin
                            r_chain[i] <= r_chain[i] + w_work[i];
                        end
                        unique case (r_next)
                            N_IDLE: r_state <= S_IDLE;
                            N_FINAL: begin
                                r_req  <= '{start: 1'b1, pad_pos: '0, mark_en: 1'b1,
                                            len_en: 1'b1};
                                r_next <= N_EMIT;
                            end
                            N_LENGTH: begin
                                r_req  <= '{start: 1'b1, pad_pos: '0, mark_en: 1'b0,
                                            len_en: 1'b1};
                                r_next <= N_EMIT;
                            end
                            N_EMIT: r_state <= S_EMIT;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (m_axis_tready) begin
                        r_chain <= {INIT_HASH[r_widx], r_chain[4:1]};
                        r_widx  <= r_widx + 3'd1;
                        if (r_widx == WORD_LAST) begin
                            r_widx  <= '0;
                            r_fill  <= '0;
                            r_count <= '0;
                            r_next  <= N_IDLE;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_EMIT);
    assign m_axis_tdata  = r_chain[0];
    assign m_axis_tuser  = r_widx;
    assign m_axis_tlast  = (r_widx == WORD_LAST);

`ifndef SYNTH
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("Input taken while digest is pending.");
    a_chain_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (r_chain == INIT_HASH))
        else $error("Chaining values not restored after digest.");
    a_emit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_widx <= WORD_LAST && !r_req.start))
        else $error("Digest word index or start out of place.");
    a_start_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req.start |-> (r_state == S_WAIT))
        else $error("Compression started outside the wait state.");
`endif

endmodule

@@ rtl/sha1mh_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 compression core
// Runs the 80 rounds of one block, one round per cycle, with a rolling
// 16-word message schedule.
// ----------------------------------------------------------------------------
module sha1mh_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha1mh_pkg::t_cmp_req i_req,
    input  sha1mh_pkg::t_block  i_block,
    input  sha1mh_pkg::t_chain  i_chain,
    input  logic [63:0]         i_bit_len,
    output logic                o_done,
    output sha1mh_pkg::t_chain  o_work
);
    import sha1mh_pkg::*;

    typedef enum logic {
        C_IDLE,
        C_ROUND
    } t_cstate;

    t_cstate    r_state;
    logic [6:0] r_round;
    logic       r_done;
    t_word      r_sched [16];
    t_word      r_a, r_b, r_c, r_d, r_e;

    t_word w_f, w_k, w_temp, w_next_sched;
    t_word w_load [16];

    always_comb begin
        if (r_round < ROUND_B1) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K_0;
        end else if (r_round < ROUND_B2) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_1;
        end else if (r_round < ROUND_B3) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K_2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_3;
        end
        w_temp = {r_a[26:0], r_a[31:27]} + w_f + r_e + r_sched[0] + w_k;
        w_next_sched = r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0];
        w_next_sched = {w_next_sched[30:0], w_next_sched[31]};
    end

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            w_load[j] = pad_word(4'(j), i_block[j], i_req.pad_pos, i_req.mark_en);
        end
        if (i_req.len_en) begin
            w_load[14] = i_bit_len[63:32];
            w_load[15] = i_bit_len[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_sched <= w_load;
                        r_a     <= i_chain[0];
                        r_b     <= i_chain[1];
                        r_c     <= i_chain[2];
                        r_d     <= i_chain[3];
                        r_e     <= i_chain[4];
                        r_round <= '0;
                        r_state <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    r_a <= w_temp;
                    r_b <= r_a;
                    r_c <= {r_b[1:0], r_b[31:2]};
                    r_d <= r_c;
                    r_e <= r_d;
                    for (int i = 0; i < 15; i++) begin
                        r_sched[i] <= r_sched[i + 1];
                    end
                    r_sched[15] <= w_next_sched;
                    r_round     <= r_round + 7'd1;
                    if (r_round == ROUND_LAST) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_work = {r_e, r_d, r_c, r_b, r_a};

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == C_IDLE)
        else $error("Compression started while busy.");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("Done held longer than one cycle.");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == C_ROUND |-> r_round <= ROUND_LAST)
        else $error("Round counter out of range.");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_ROUND && r_round == ROUND_LAST) |=> (r_done && r_state == C_IDLE))
        else $error("Last round did not finish the block.");
`endif

endmodule

@@ bench/sha1_digest_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches both streams of the hasher. It runs its own SHA-1 over every
// accepted byte beat, queues five digest beats when a message closes, and
// compares each delivered digest beat field by field with the oldest one.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // digest_word[31:0]
    input  logic [2:0]  m_axis_tuser,   // word_index[2:0]
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_messages,
    output int          o_bytes,
    output int          o_words
);

    localparam logic [31:0] IV_0 = 32'h67452301;
    localparam logic [31:0] IV_1 = 32'hefcdab89;
    localparam logic [31:0] IV_2 = 32'h98badcfe;
    localparam logic [31:0] IV_3 = 32'h10325476;
    localparam logic [31:0] IV_4 = 32'hc3d2e1f0;
    localparam logic [31:0] RK_0 = 32'h5a827999;
    localparam logic [31:0] RK_1 = 32'h6ed9eba1;
    localparam logic [31:0] RK_2 = 32'h8f1bbcdc;
    localparam logic [31:0] RK_3 = 32'hca62c1d6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int          DIGEST_WORDS = 5;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    t_digest_beat digest_due [$];

    logic [31:0] chain_h [5];
    logic [31:0] block_buf [16];
    logic [6:0]  fill_level;
    logic [60:0] byte_total;

    int fails;
    int messages;
    int bytes_seen;
    int words_seen;

    function automatic void restart_message();
        chain_h[0] = IV_0;
        chain_h[1] = IV_1;
        chain_h[2] = IV_2;
        chain_h[3] = IV_3;
        chain_h[4] = IV_4;
        foreach (block_buf[i]) block_buf[i] = '0;
        fill_level = '0;
        byte_total = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] sched [80];
        logic [31:0] a, b, c, d, e, f, k, nx;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 16) begin
                sched[r] = block_buf[r];
            end else begin
                nx = sched[r - 3] ^ sched[r - 8] ^ sched[r - 14] ^ sched[r - 16];
                sched[r] = {nx[30:0], nx[31]};
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = RK_0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = RK_1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RK_2;
            end else begin
                f = b ^ c ^ d;
                k = RK_3;
            end
            nx = {a[26:0], a[31:27]} + f + e + sched[r] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = nx;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
        foreach (block_buf[i]) block_buf[i] = '0;
    endfunction

    function automatic void place_byte(input logic [7:0] value);
        logic [5:0] pos;
        pos = fill_level[5:0];
        block_buf[pos[5:2]] = block_buf[pos[5:2]]
                              | ({24'h0, value} << (8 * (3 - int'(pos[1:0]))));
    endfunction

    function automatic void absorb_byte(input logic [7:0] value);
        place_byte(value);
        byte_total = byte_total + 61'd1;
        fill_level = fill_level + 7'd1;
        if (fill_level >= 7'd64) begin
            sha1_compress();
            fill_level = '0;
        end
    endfunction

    function automatic void close_message();
        logic [63:0]  bit_len;
        t_digest_beat beat;
        place_byte(PAD_BYTE);
        if (fill_level >= 7'd56) sha1_compress();
        bit_len = {byte_total, 3'b000};
        block_buf[14] = bit_len[63:32];
        block_buf[15] = bit_len[31:0];
        sha1_compress();
        for (int i = 0; i < DIGEST_WORDS; i++) begin
            beat.word  = chain_h[i];
            beat.index = 3'(i);
            beat.last  = (i == DIGEST_WORDS - 1);
            digest_due.push_back(beat);
        end
        restart_message();
    endfunction

    function automatic void compare_digest_beat();
        t_digest_beat want;
        words_seen++;
        if (digest_due.size() == 0) begin
            $error("unexpected digest beat: digest_word %h, word_index %0d, last_word %b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
            fails++;
            return;
        end
        want = digest_due.pop_front();
        if (m_axis_tdata !== want.word) begin
            $error("digest_word mismatch: expected %h, actual %h", want.word, m_axis_tdata);
            fails++;
        end
        if (m_axis_tuser !== want.index) begin
            $error("word_index mismatch: expected %0d, actual %0d", want.index, m_axis_tuser);
            fails++;
        end
        if (m_axis_tlast !== want.last) begin
            $error("last_word mismatch: expected %b, actual %b", want.last, m_axis_tlast);
            fails++;
        end
    endfunction

    initial begin
        fails      = 0;
        messages   = 0;
        bytes_seen = 0;
        words_seen = 0;
        restart_message();
        o_fail_count = 0;
        o_pending    = 0;
        o_messages   = 0;
        o_bytes      = 0;
        o_words      = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_message();
            digest_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) compare_digest_beat();
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser) begin
                    absorb_byte(s_axis_tdata);
                    bytes_seen++;
                end
                if (s_axis_tlast) begin
                    close_message();
                    messages++;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= digest_due.size();
        o_messages   <= messages;
        o_bytes      <= bytes_seen;
        o_words      <= words_seen;
    end

endmodule

@@ bench/sha1_message_hasher_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message hasher testbench
// Feeds directed and random messages into the hasher with random gaps and
// output stalls; the digest checker predicts and compares every digest beat.
// ----------------------------------------------------------------------------
module sha1_message_hasher_top_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte[7:0]
    logic        s_axis_tuser;   // byte_present
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // digest_word[31:0]
    logic [2:0]  m_axis_tuser;   // word_index[2:0]
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int messages;
    int bytes_hashed;
    int words_checked;

    int random_items;
    int boundary_lens [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

    sha1_message_hasher_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha1_digest_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_messages    (messages),
        .o_bytes       (bytes_hashed),
        .o_words       (words_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic send_beat(input logic [7:0] value, input logic has_byte,
                             input logic ends, input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= has_byte;
        s_axis_tlast  <= ends;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Noise beats carry neither a byte nor the end mark and are not counted.
    task automatic send_message(input int len, input bit calm);
        bit joined;
        joined = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if (!calm && $urandom_range(0, 9) == 0) begin
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, calm);
            end
            send_beat(8'($urandom_range(0, 255)), 1'b1, joined && (i == len - 1), calm);
            random_items++;
        end
        if (!joined) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, calm);
            random_items++;
        end
    endtask

    initial begin
        int calm_left;
        int stall;
        m_axis_tready = 1'b0;
        calm_left     = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (calm_left > 0) begin
                stall = 0;
                calm_left--;
            end else begin
                stall = $urandom_range(0, 8);
                if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(5, 15);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin
        int len;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        random_items  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_beat(8'hA5, 1'b0, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0, 1'b0);
        send_beat(8'h61, 1'b1, 1'b0, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0, 1'b0);
        send_beat(8'h3C, 1'b0, 1'b0, 1'b0);
        send_beat(8'h80, 1'b1, 1'b0, 1'b0);
        send_beat(8'h5A, 1'b0, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b1, 1'b1);
        wait_idle();

        // Lengths at the point where padding needs a second block and at the block edge.
        for (int i = 0; i < 4; i++) begin
            send_message(boundary_lens[i + (i > 1 ? 1 : 0)], $urandom_range(0, 3) == 0);
        end
        while (random_items < 400) begin
            if ($urandom_range(0, 5) == 0) len = boundary_lens[$urandom_range(0, 8)];
            else len = $urandom_range(0, 24);
            send_message(len, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) wait_idle();
        end
        wait_idle();
        repeat (200) @(posedge i_clk);

        $display("Hashed %0d messages totalling %0d bytes; %0d digest beats compared.",
                 messages, bytes_hashed, words_checked);
        $display("Lengths spanned empty messages, the 55/56-byte padding edge and multi-block runs.");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
